// ----- rtl/core/npc_pkg.sv -----
// Shared constants and stage record for the near-plane triangle clipper.
// No dependencies; every module of the clipper imports this package.
package npc_pkg;

    localparam int CW     = 32;
    localparam int FB     = 16;
    localparam int DSTEP  = 2;
    localparam int DS     = (FB + DSTEP - 1) / DSTEP;
    localparam int NST    = DS + 4;
    localparam int STEP_W = $clog2(DS * DSTEP + 1);

    localparam logic [CW-1:0] NEAR_RST = CW'(((1 << FB) + 5) / 10);

    localparam logic [1:0] K_PASS = 2'd0;
    localparam logic [1:0] K_ONE  = 2'd1;
    localparam logic [1:0] K_TWO  = 2'd2;

    typedef logic [2:0][CW-1:0] t_vert;

    typedef struct packed {
        logic [CW+1:0]  rem;
        logic [CW:0]    den;
        logic [FB-1:0]  t;
        logic [CW-1:0]  px;
        logic [CW-1:0]  py;
        logic           nx;
        logic           ny;
        logic [CW:0]    mx;
        logic [CW:0]    my;
        logic [CW+FB:0] prx;
        logic [CW+FB:0] pry;
        logic [CW-1:0]  rx;
        logic [CW-1:0]  ry;
        logic           sat;
    } t_lane;

    typedef struct packed {
        logic [2:0][2:0][CW-1:0] v;
        logic [1:0]              kind;
        logic [1:0]              idx;   // behind vertex (one behind) or front vertex (two)
        t_lane                   la;
        t_lane                   lb;
    } t_item;

endpackage

// ----- rtl/core/npc_setup.sv -----
// Classifies the triangle against the near plane and sets up both clip lanes.
// Depends on npc_pkg.
module npc_setup (
    input  npc_pkg::t_item          i_item,
    input  logic [npc_pkg::CW-1:0]  i_near,
    output npc_pkg::t_item          o_item
);
    import npc_pkg::*;

    function automatic t_lane mk_lane(input t_vert p, input t_vert q,
                                      input logic [CW-1:0] near);
        t_lane l;
        logic signed [CW:0] n;
        logic signed [CW:0] d;
        logic signed [CW:0] dx;
        logic signed [CW:0] dy;
        l   = '0;
        n   = $signed({near[CW-1], near}) - $signed({p[2][CW-1], p[2]});
        d   = $signed({q[2][CW-1], q[2]}) - $signed({p[2][CW-1], p[2]});
        dx  = $signed({q[0][CW-1], q[0]}) - $signed({p[0][CW-1], p[0]});
        dy  = $signed({q[1][CW-1], q[1]}) - $signed({p[1][CW-1], p[1]});
        l.rem = {1'b0, n};
        l.den = d;
        l.px  = p[0];
        l.py  = p[1];
        l.nx  = dx[CW];
        l.ny  = dy[CW];
        l.mx  = dx[CW] ? -dx : dx;
        l.my  = dy[CW] ? -dy : dy;
        return l;
    endfunction

    logic [2:0] bh;
    logic [2:0] fr;
    logic [1:0] ia, qa, ib, qb;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            bh[i] = $signed(i_item.v[i][2]) < $signed(i_near);
            fr[i] = $signed(i_item.v[i][2]) > $signed(i_near);
        end
        o_item      = i_item;
        o_item.kind = K_PASS;
        o_item.idx  = 2'd0;
        ia = 2'd0; qa = 2'd1; ib = 2'd0; qb = 2'd2;
        priority if (bh[0] && fr[1] && fr[2]) begin
            o_item.kind = K_ONE; o_item.idx = 2'd0;
            ia = 2'd0; qa = 2'd2; ib = 2'd0; qb = 2'd1;
        end else if (bh[1] && fr[0] && fr[2]) begin
            o_item.kind = K_ONE; o_item.idx = 2'd1;
            ia = 2'd1; qa = 2'd2; ib = 2'd1; qb = 2'd0;
        end else if (bh[2] && fr[0] && fr[1]) begin
            o_item.kind = K_ONE; o_item.idx = 2'd2;
            ia = 2'd2; qa = 2'd1; ib = 2'd2; qb = 2'd0;
        end else if (bh[1] && bh[2] && fr[0]) begin
            o_item.kind = K_TWO; o_item.idx = 2'd0;
            ia = 2'd1; qa = 2'd0; ib = 2'd2; qb = 2'd0;
        end else if (bh[0] && bh[1] && fr[2]) begin
            o_item.kind = K_TWO; o_item.idx = 2'd2;
            ia = 2'd0; qa = 2'd2; ib = 2'd1; qb = 2'd2;
        end else if (bh[0] && bh[2] && fr[1]) begin
            o_item.kind = K_TWO; o_item.idx = 2'd1;
            ia = 2'd0; qa = 2'd1; ib = 2'd2; qb = 2'd1;
        end else begin
            o_item.kind = K_PASS;
        end
        o_item.la = mk_lane(i_item.v[ia], i_item.v[qa], i_near);
        o_item.lb = mk_lane(i_item.v[ib], i_item.v[qb], i_near);
    end

endmodule

// ----- rtl/core/npc_div.sv -----
// Up to DSTEP restoring-division steps of t = num * 2^FB / den, for both lanes.
// Depends on npc_pkg.
module npc_div (
    input  npc_pkg::t_item             i_item,
    input  logic [npc_pkg::STEP_W-1:0] i_first,
    output npc_pkg::t_item             o_item
);
    import npc_pkg::*;

    function automatic t_lane div_step(input t_lane l);
        t_lane o;
        logic [CW+1:0] sh;
        o  = l;
        sh = {l.rem[CW:0], 1'b0};
        if (sh >= {1'b0, l.den}) begin
            o.rem = sh - {1'b0, l.den};
            o.t   = {l.t[FB-2:0], 1'b1};
        end else begin
            o.rem = sh;
            o.t   = {l.t[FB-2:0], 1'b0};
        end
        return o;
    endfunction

    always_comb begin
        o_item = i_item;
        for (int s = 0; s < DSTEP; s++) begin
            if (int'(i_first) + s < FB) begin
                o_item.la = div_step(o_item.la);
                o_item.lb = div_step(o_item.lb);
            end
        end
    end

endmodule

// ----- rtl/core/npc_mul.sv -----
// Scales the edge deltas by t: four (CW+1) x FB products.
// Depends on npc_pkg.
module npc_mul (
    input  npc_pkg::t_item i_item,
    output npc_pkg::t_item o_item
);
    import npc_pkg::*;

    always_comb begin
        o_item        = i_item;
        o_item.la.prx = (CW+FB+1)'(i_item.la.mx) * (CW+FB+1)'(i_item.la.t);
        o_item.la.pry = (CW+FB+1)'(i_item.la.my) * (CW+FB+1)'(i_item.la.t);
        o_item.lb.prx = (CW+FB+1)'(i_item.lb.mx) * (CW+FB+1)'(i_item.lb.t);
        o_item.lb.pry = (CW+FB+1)'(i_item.lb.my) * (CW+FB+1)'(i_item.lb.t);
    end

endmodule

// ----- rtl/core/npc_fin.sv -----
// Adds the scaled delta to the behind vertex and clamps to the coordinate range.
// Depends on npc_pkg.
module npc_fin (
    input  npc_pkg::t_item i_item,
    output npc_pkg::t_item o_item
);
    import npc_pkg::*;

    function automatic logic [CW:0] fin_coord(input logic [CW-1:0] p, input logic neg,
                                              input logic [CW+FB:0] pr);
        logic [CW+1:0] ps;
        logic [CW+1:0] ms;
        logic [CW+1:0] r;
        logic [CW-1:0] c;
        logic          ovf;
        ps  = {{2{p[CW-1]}}, p};
        ms  = {1'b0, pr[CW+FB:FB]};
        r   = neg ? ps - ms : ps + ms;
        ovf = !((r[CW+1:CW-1] == 3'b000) || (r[CW+1:CW-1] == 3'b111));
        if (!ovf) c = r[CW-1:0];
        else if (r[CW+1]) c = {1'b1, {(CW-1){1'b0}}};
        else c = {1'b0, {(CW-1){1'b1}}};
        return {ovf, c};
    endfunction

    logic [CW:0] ax, ay, bx, by;

    always_comb begin
        ax = fin_coord(i_item.la.px, i_item.la.nx, i_item.la.prx);
        ay = fin_coord(i_item.la.py, i_item.la.ny, i_item.la.pry);
        bx = fin_coord(i_item.lb.px, i_item.lb.nx, i_item.lb.prx);
        by = fin_coord(i_item.lb.py, i_item.lb.ny, i_item.lb.pry);
        o_item        = i_item;
        o_item.la.rx  = ax[CW-1:0];
        o_item.la.ry  = ay[CW-1:0];
        o_item.la.sat = ax[CW] | ay[CW];
        o_item.lb.rx  = bx[CW-1:0];
        o_item.lb.ry  = by[CW-1:0];
        o_item.lb.sat = bx[CW] | by[CW];
    end

endmodule

// ----- rtl/core/near_plane_triangle_clipper.sv -----
// Near-plane triangle clipper, top level. Depends on npc_pkg and the stage modules.
// NST pipeline stages; one triangle per cycle while o_ready is high and no split
// triangle holds the output stage: a one-vertex-behind triangle leaves as two beats,
// and the output stage holds it until both have gone. Division runs DSTEP bits per stage.
// Reset (synchronous, active low) empties the pipeline and loads near_plane_z = 6554.
module near_plane_triangle_clipper (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic signed [npc_pkg::CW-1:0] i_cfg_data,
    input  logic                          i_valid,
    output logic                          i_ready,
    input  logic signed [npc_pkg::CW-1:0] i_v0_x,
    input  logic signed [npc_pkg::CW-1:0] i_v0_y,
    input  logic signed [npc_pkg::CW-1:0] i_v0_z,
    input  logic signed [npc_pkg::CW-1:0] i_v1_x,
    input  logic signed [npc_pkg::CW-1:0] i_v1_y,
    input  logic signed [npc_pkg::CW-1:0] i_v1_z,
    input  logic signed [npc_pkg::CW-1:0] i_v2_x,
    input  logic signed [npc_pkg::CW-1:0] i_v2_y,
    input  logic signed [npc_pkg::CW-1:0] i_v2_z,
    output logic                          o_valid,
    input  logic                          o_ready,
    output logic signed [npc_pkg::CW-1:0] o_out0_x,
    output logic signed [npc_pkg::CW-1:0] o_out0_y,
    output logic signed [npc_pkg::CW-1:0] o_out0_z,
    output logic signed [npc_pkg::CW-1:0] o_out1_x,
    output logic signed [npc_pkg::CW-1:0] o_out1_y,
    output logic signed [npc_pkg::CW-1:0] o_out1_z,
    output logic signed [npc_pkg::CW-1:0] o_out2_x,
    output logic signed [npc_pkg::CW-1:0] o_out2_y,
    output logic signed [npc_pkg::CW-1:0] o_out2_z,
    output logic                          o_is_added_face,
    output logic                          o_last_of_run,
    output logic                          o_saturated
);
    import npc_pkg::*;

    localparam int L = NST - 1;

    logic [CW-1:0] r_near;
    logic          r_phase;
    logic [NST-1:0] r_v;
    t_item          r_item [NST];
    t_item          n_item [NST];
    logic [NST:0]   load;
    logic           done;
    t_item          f;
    t_vert          va, vb;
    logic [2:0][2:0][CW-1:0] c;
    logic           sat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_near <= NEAR_RST;
        end else if (i_cfg_we) begin
            r_near <= i_cfg_data;
        end
    end

    always_comb begin
        n_item[0]         = '0;
        n_item[0].v[0][0] = i_v0_x;
        n_item[0].v[0][1] = i_v0_y;
        n_item[0].v[0][2] = i_v0_z;
        n_item[0].v[1][0] = i_v1_x;
        n_item[0].v[1][1] = i_v1_y;
        n_item[0].v[1][2] = i_v1_z;
        n_item[0].v[2][0] = i_v2_x;
        n_item[0].v[2][1] = i_v2_y;
        n_item[0].v[2][2] = i_v2_z;
    end

    npc_setup u_setup (.i_item(r_item[0]), .i_near(r_near), .o_item(n_item[1]));

    for (genvar g = 0; g < DS; g++) begin : g_div
        npc_div u_div (
            .i_item (r_item[1+g]),
            .i_first(STEP_W'(g * DSTEP)),
            .o_item (n_item[2+g])
        );
    end

    npc_mul u_mul (.i_item(r_item[DS+1]), .o_item(n_item[DS+2]));
    npc_fin u_fin (.i_item(r_item[DS+2]), .o_item(n_item[DS+3]));

    // a stage loads when empty or when its beat moves on
    always_comb begin
        done      = r_v[L] && o_ready && ((r_item[L].kind != K_ONE) || r_phase);
        load[NST] = done;
        for (int k = NST - 1; k >= 0; k--) begin
            load[k] = !r_v[k] || load[k+1];
        end
    end

    assign i_ready = load[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v     <= '0;
            r_phase <= 1'b0;
        end else begin
            if (load[0]) r_v[0] <= i_valid;
            for (int k = 1; k < NST; k++) begin
                if (load[k]) r_v[k] <= r_v[k-1];
            end
            if (o_valid && o_ready) begin
                r_phase <= (r_item[L].kind == K_ONE) && !r_phase;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < NST; k++) begin
            if (load[k]) r_item[k] <= n_item[k];
        end
    end

    // output beat assembly
    always_comb begin
        f  = r_item[L];
        va = {r_near, f.la.ry, f.la.rx};
        vb = {r_near, f.lb.ry, f.lb.rx};
        c  = f.v;
        sat = 1'b0;
        o_is_added_face = 1'b0;
        o_last_of_run   = 1'b1;
        unique case (f.kind)
            K_ONE: begin
                if (!r_phase) begin
                    c[f.idx] = va;
                    sat = f.la.sat;
                    o_last_of_run = 1'b0;
                end else begin
                    c[0] = vb;
                    c[1] = va;
                    c[2] = (f.idx == 2'd0) ? f.v[1] : f.v[0];
                    sat = f.la.sat | f.lb.sat;
                    o_is_added_face = 1'b1;
                end
            end
            K_TWO: begin
                unique case (f.idx)
                    2'd0: begin c[1] = va; c[2] = vb; end
                    2'd1: begin c[0] = va; c[2] = vb; end
                    default: begin c[0] = va; c[1] = vb; end
                endcase
                sat = f.la.sat | f.lb.sat;
            end
            default: begin
                sat = 1'b0;
            end
        endcase
    end

    assign o_valid     = r_v[L];
    assign o_saturated = sat;
    assign o_out0_x = c[0][0];
    assign o_out0_y = c[0][1];
    assign o_out0_z = c[0][2];
    assign o_out1_x = c[1][0];
    assign o_out1_y = c[1][1];
    assign o_out1_z = c[1][2];
    assign o_out2_x = c[2][0];
    assign o_out2_y = c[2][1];
    assign o_out2_z = c[2][2];

`ifndef SYNTHESIS
    a_phase_split: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase |-> (r_v[L] && (r_item[L].kind == K_ONE)))
        else $error("second beat pending without a split triangle");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_ready) |=> o_valid)
        else $error("output beat dropped while stalled");
    a_empty_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_v[0] |-> i_ready)
        else $error("input stage empty but not ready");
    a_first_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (r_item[L].kind == K_ONE) && !r_phase) |-> !o_last_of_run)
        else $error("first beat of split marked last");
`endif

endmodule

// ----- tb/sv/near_plane_triangle_clipper_checker.sv -----
// Scoreboard for the near-plane triangle clipper: watches the input, config and output
// channels, predicts the emitted triangles and compares them. Depends on npc_pkg.
module near_plane_triangle_clipper_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [npc_pkg::CW-1:0]        i_cfg_data,
    input  logic                          i_in_valid,
    input  logic                          i_in_ready,
    input  logic [8:0][npc_pkg::CW-1:0]   i_tri,
    input  logic                          i_out_valid,
    input  logic                          i_out_ready,
    input  logic [8:0][npc_pkg::CW-1:0]   i_face,
    input  logic                          i_added,
    input  logic                          i_last,
    input  logic                          i_sat,
    output int                            o_pending,
    output int                            o_fails
);
    timeunit 1ns;
    timeprecision 1ps;

    import npc_pkg::*;

    typedef struct packed {
        logic [8:0][CW-1:0] crd;
        logic               added;
        logic               last;
        logic               sat;
    } t_face;

    t_face       face_q[$];
    longint      plane_z;
    int          fails;

    assign o_pending = face_q.size();
    assign o_fails   = fails;

    function automatic void enqueue_face(input t_face f);
        face_q = {face_q, f};
    endfunction

    function automatic longint clamp32(input longint val, inout bit sat);
        if (val > 64'sd2147483647) begin
            sat = 1'b1;
            return 64'sd2147483647;
        end
        if (val < -64'sd2147483648) begin
            sat = 1'b1;
            return -64'sd2147483648;
        end
        return val;
    endfunction

    function automatic longint step_toward(input longint a, input longint b,
                                           input longint frac, inout bit sat);
        longint d;
        longint m;
        d = b - a;
        m = ((d < 0) ? -d : d) * frac;
        m = m >>> FB;
        return clamp32((d < 0) ? a - m : a + m, sat);
    endfunction

    // p behind the plane, q in front; rounding of the edge point is toward p
    function automatic void clip_edge(input longint p[3], input longint q[3],
                                      output longint o[3], inout bit sat);
        longint num;
        longint den;
        longint frac;
        num  = plane_z - p[2];
        den  = q[2] - p[2];
        frac = 0;
        for (int i = 0; i < FB; i++) begin
            num  = num << 1;
            frac = frac << 1;
            if (num >= den) begin
                num  = num - den;
                frac = frac | 1;
            end
        end
        o[0] = step_toward(p[0], q[0], frac, sat);
        o[1] = step_toward(p[1], q[1], frac, sat);
        o[2] = plane_z;
    endfunction

    function automatic t_face make_face(input longint a[3], input longint b[3],
                                        input longint c[3], input bit added,
                                        input bit last, input bit sat);
        t_face f;
        for (int j = 0; j < 3; j++) begin
            f.crd[j]     = a[j][CW-1:0];
            f.crd[3 + j] = b[j][CW-1:0];
            f.crd[6 + j] = c[j][CW-1:0];
        end
        f.added = added;
        f.last  = last;
        f.sat   = sat;
        return f;
    endfunction

    function automatic void predict_faces(input logic [8:0][CW-1:0] tri_in);
        longint v0[3], v1[3], v2[3];
        longint c0[3], c1[3], c2[3];
        longint ex[3];
        bit     bh[3], fr[3];
        bit     s0, s1;
        for (int j = 0; j < 3; j++) begin
            v0[j] = longint'(signed'(tri_in[j]));
            v1[j] = longint'(signed'(tri_in[3 + j]));
            v2[j] = longint'(signed'(tri_in[6 + j]));
        end
        c0 = v0; c1 = v1; c2 = v2;
        bh[0] = v0[2] < plane_z; fr[0] = v0[2] > plane_z;
        bh[1] = v1[2] < plane_z; fr[1] = v1[2] > plane_z;
        bh[2] = v2[2] < plane_z; fr[2] = v2[2] > plane_z;
        s0 = 0;
        s1 = 0;
        if (bh[0] && fr[1] && fr[2]) begin
            clip_edge(v0, v2, c0, s0);
            clip_edge(v0, v1, ex, s1);
            enqueue_face(make_face(c0, v1, v2, 0, 0, s0));
            enqueue_face(make_face(ex, c0, v1, 1, 1, s0 | s1));
        end else if (bh[1] && fr[0] && fr[2]) begin
            clip_edge(v1, v2, c1, s0);
            clip_edge(v1, v0, ex, s1);
            enqueue_face(make_face(v0, c1, v2, 0, 0, s0));
            enqueue_face(make_face(ex, c1, v0, 1, 1, s0 | s1));
        end else if (bh[2] && fr[0] && fr[1]) begin
            clip_edge(v2, v1, c2, s0);
            clip_edge(v2, v0, ex, s1);
            enqueue_face(make_face(v0, v1, c2, 0, 0, s0));
            enqueue_face(make_face(ex, c2, v0, 1, 1, s0 | s1));
        end else begin
            if (bh[1] && bh[2] && fr[0]) begin
                clip_edge(v2, v0, c2, s0);
                clip_edge(v1, v0, c1, s0);
            end else if (bh[0] && bh[1] && fr[2]) begin
                clip_edge(v0, v2, c0, s0);
                clip_edge(v1, v2, c1, s0);
            end else if (bh[0] && bh[2] && fr[1]) begin
                clip_edge(v0, v1, c0, s0);
                clip_edge(v2, v1, c2, s0);
            end
            enqueue_face(make_face(c0, c1, c2, 0, 1, s0));
        end
    endfunction

    always @(posedge i_clk) begin
        t_face got;
        t_face want;
        if (!i_rst_n) begin
            plane_z = longint'(signed'(NEAR_RST));
            face_q.delete();
        end else begin
            if (i_cfg_we)
                plane_z = longint'(signed'(i_cfg_data));
            if (i_in_valid && i_in_ready)
                predict_faces(i_tri);
            if (i_out_valid && i_out_ready) begin
                got = {i_face, i_added, i_last, i_sat};
                if (face_q.size() == 0) begin
                    fails++;
                    if (fails <= 10)
                        $display("unexpected output beat: %h", got);
                end else begin
                    want = face_q.pop_front();
                    if (got !== want) begin
                        fails++;
                        if (fails <= 10)
                            $display("face mismatch: exp %h act %h", want, got);
                    end
                end
            end
        end
    end

    initial fails = 0;

    final begin
        if (face_q.size() != 0)
            $display("%0d faces never emitted", face_q.size());
    end
endmodule

// ----- tb/sv/tb_near_plane_triangle_clipper.sv -----
// Top of the clipper testbench: clock, reset, triangle and config stimulus, output stalls
// and the verdict. Depends on npc_pkg, the clipper RTL and the clipper checker.
module tb_near_plane_triangle_clipper;
    timeunit 1ns;
    timeprecision 1ps;

    import npc_pkg::*;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int DRAIN_CYCLES   = 2 * NST + 4;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CW-1:0]        cfg_data;
    logic                 in_valid;
    logic                 in_ready;
    logic [8:0][CW-1:0]   tri_in;
    logic                 out_valid;
    logic                 out_ready;
    logic [8:0][CW-1:0]   face;
    logic                 added, last, sat;
    int                   pending;
    int                   fails;
    int                   quiet_cycles;
    bit                   no_gaps;
    bit                   timed_out;
    longint               plane;

    near_plane_triangle_clipper u_dut (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_cfg_we(cfg_we), .i_cfg_data(cfg_data),
        .i_valid(in_valid), .i_ready(in_ready),
        .i_v0_x(tri_in[0]), .i_v0_y(tri_in[1]), .i_v0_z(tri_in[2]),
        .i_v1_x(tri_in[3]), .i_v1_y(tri_in[4]), .i_v1_z(tri_in[5]),
        .i_v2_x(tri_in[6]), .i_v2_y(tri_in[7]), .i_v2_z(tri_in[8]),
        .o_valid(out_valid), .o_ready(out_ready),
        .o_out0_x(face[0]), .o_out0_y(face[1]), .o_out0_z(face[2]),
        .o_out1_x(face[3]), .o_out1_y(face[4]), .o_out1_z(face[5]),
        .o_out2_x(face[6]), .o_out2_y(face[7]), .o_out2_z(face[8]),
        .o_is_added_face(added), .o_last_of_run(last), .o_saturated(sat)
    );

    near_plane_triangle_clipper_checker u_checker (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_cfg_we(cfg_we), .i_cfg_data(cfg_data),
        .i_in_valid(in_valid), .i_in_ready(in_ready), .i_tri(tri_in),
        .i_out_valid(out_valid), .i_out_ready(out_ready), .i_face(face),
        .i_added(added), .i_last(last), .i_sat(sat),
        .o_pending(pending), .o_fails(fails)
    );

    initial begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    function automatic int draw_gap();
        if (no_gaps)
            return 0;
        return $urandom_range(0, 17);
    endfunction

    // depth relative to the plane: behind, in front, on it, far off or anything
    function automatic logic [CW-1:0] pick_depth();
        longint off;
        case ($urandom_range(0, 9))
            0, 1, 2: off = -longint'($urandom_range(1, 200000));
            3, 4, 5: off = longint'($urandom_range(1, 200000));
            6:       off = 0;
            7:       off = -longint'($urandom);
            8:       off = longint'($urandom);
            default: return $urandom;
        endcase
        return CW'(plane + off);
    endfunction

    function automatic logic [CW-1:0] pick_coord();
        if ($urandom_range(0, 3) == 0)
            return $urandom;
        return CW'(longint'($urandom_range(0, 2000000)) - 1000000);
    endfunction

    task automatic send_tri(input logic [8:0][CW-1:0] t);
        int gap;
        gap = draw_gap();
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        tri_in   <= t;
        do @(posedge clk); while (!in_ready);
    endtask

    task automatic send_random_tri();
        logic [8:0][CW-1:0] t;
        for (int i = 0; i < 3; i++) begin
            t[3*i]     = pick_coord();
            t[3*i + 1] = pick_coord();
            t[3*i + 2] = pick_depth();
        end
        send_tri(t);
    endtask

    // z codes: -1 behind, 0 on the plane, 1 in front
    task automatic send_shape(input int z0, input int z1, input int z2,
                              input logic [CW-1:0] xy);
        logic [8:0][CW-1:0] t;
        int zc[3];
        zc = '{z0, z1, z2};
        for (int i = 0; i < 3; i++) begin
            t[3*i]     = (i == 1) ? ~xy : xy;
            t[3*i + 1] = (i == 2) ? ~xy : xy ^ 32'h5a5a_0f0f;
            t[3*i + 2] = CW'(plane + zc[i] * longint'(1000 * (i + 1)));
        end
        send_tri(t);
    endtask

    // the checker records the last accepted beat only at the next edge
    task automatic wait_idle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_plane(input logic [CW-1:0] val);
        cfg_we   <= 1'b1;
        cfg_data <= val;
        @(posedge clk);
        cfg_we   <= 1'b0;
        plane = longint'(signed'(val));
        @(posedge clk);
    endtask

    task automatic run_directed();
        send_shape(1, 1, 1, 32'h0001_0000);
        send_shape(-1, -1, -1, 32'h0001_0000);
        send_shape(-1, 1, 1, 32'h0003_8000);
        send_shape(1, -1, 1, 32'h7fff_ffff);
        send_shape(1, 1, -1, 32'h8000_0000);
        send_shape(1, -1, -1, 32'h0000_0000);
        send_shape(-1, -1, 1, 32'hffff_ffff);
        send_shape(-1, 1, -1, 32'h8000_0000);
        send_shape(0, 1, -1, 32'h0002_0000);
        send_shape(-1, 0, 1, 32'h0002_0000);
        send_shape(0, 0, 0, 32'h0002_0000);
        // widest edges: opposite corners of the coordinate range
        send_tri({32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
                  32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff,
                  32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000});
        send_tri({32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff,
                  32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000,
                  32'h8000_0000, 32'h8000_0000, 32'h8000_0000});
    endtask

    initial begin : out_stall
        int gap;
        out_ready = 1'b0;
        @(posedge clk);
        while (!rst_n) @(posedge clk);
        forever begin
            gap = draw_gap();
            if (gap > 0) begin
                out_ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!out_valid);
        end
    end

    initial begin : watchdog
        quiet_cycles = 0;
        timed_out    = 0;
        forever begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                timed_out = 1;
                $display("Some tests failed");
                $finish;
            end
        end
    end

    initial begin : stimulus
        logic [CW-1:0] planes[6];
        rst_n    = 1'b0;
        cfg_we   = 1'b0;
        cfg_data = '0;
        in_valid = 1'b0;
        tri_in   = '0;
        no_gaps  = 0;
        plane    = longint'(signed'(NEAR_RST));
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset value first, then written settings including both extremes
        planes = '{NEAR_RST, 32'h0000_0000, 32'h8000_0000, 32'h7fff_ffff,
                   32'hfffe_8000, $urandom};
        run_directed();
        for (int ph = 0; ph < 6; ph++) begin
            wait_idle();
            write_plane(planes[ph]);
            if (ph == 1)
                run_directed();
            for (int n = 0; n < 180; n++) begin
                // stretches with no stalls on either side
                if (n % 60 == 0)
                    no_gaps = ($urandom_range(0, 2) == 0);
                send_random_tri();
            end
            no_gaps = 0;
        end
        wait_idle();

        if (fails == 0 && pending == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end
endmodule
